// ===== rtl/pct_pkg.sv =====
// Shared types, state codes and helper functions for the prefix context table.
package pct_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int ID_W        = 4;
	localparam int PFX_W       = 128;

	// Request function codes
	localparam logic [1:0] FUNC_ADDR = 2'd0;
	localparam logic [1:0] FUNC_ID   = 2'd1;
	localparam logic [1:0] FUNC_UPD  = 2'd2;

	localparam logic [7:0] MAX_LEN = 8'd128;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_UPD,
		ST_DONE
	} pct_state_t;

	// One stored context
	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
		logic [7:0]  len;
		logic [15:0] life;
		logic [31:0] expiry;
	} pct_entry_t;

	// Write command into the context store
	typedef struct packed {
		logic        life_we;
		logic        meta_we;
		logic        pfx_we;
		logic [15:0] life;
		logic [7:0]  len;
		logic [31:0] expiry;
		logic [63:0] hi;
		logic [63:0] lo;
	} pct_wr_t;

	// Entry after refresh, as held in the unit's output register
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [15:0]      life;
		logic [7:0]       len;
		logic [63:0]      hi;
		logic [63:0]      lo;
		logic [PFX_W-1:0] diff;
	} pct_s1_t;

	// Remaining lifetime at minute now; zero once expiry is reached
	function automatic logic [15:0] refresh_life(input logic [15:0] life,
		input logic [31:0] expiry, input logic [31:0] now);
		logic [32:0] d;
		logic [15:0] r;
		d = {1'b0, expiry} - {1'b0, now};
		if (life == 16'd0 || d[32] || d[31:0] == 32'd0) begin
			r = 16'd0;
		end else if (d[31:16] != 16'd0) begin
			r = 16'hFFFF;
		end else begin
			r = d[15:0];
		end
		return r;
	endfunction

	// Leading zero count of a 128-bit word, 128 when all zero
	function automatic logic [7:0] lead_zeros(input logic [PFX_W-1:0] diff);
		logic [PFX_W-1:0] v;
		logic [7:0]       n;
		v = diff;
		n = 8'd0;
		for (int s = 6; s >= 0; s--) begin
			if ((v >> (PFX_W - (1 << s))) == '0) begin
				n = n + 8'(1 << s);
				v = v << (1 << s);
			end
		end
		if (!v[PFX_W-1]) begin
			n = n + 8'd1;
		end
		return n;
	endfunction

	// Mask keeping the leading plen bits
	function automatic logic [PFX_W-1:0] len_mask(input logic [7:0] plen);
		logic [PFX_W-1:0] m;
		for (int i = 0; i < PFX_W; i++) begin
			m[i] = ({1'b0, 7'(PFX_W - 1 - i)} < plen);
		end
		return m;
	endfunction

endpackage

// ===== rtl/pct_store.sv =====
// Context store: one register entry per context, one read and one write port.
module pct_store import pct_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int IDW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [IDW-1:0] rd_addr,
	output pct_entry_t     rd_data,
	input  logic [IDW-1:0] wr_addr,
	input  pct_wr_t        wr
);

	pct_entry_t entry_q [ENTRIES];

	logic rd_ok;
	logic wr_ok;

	assign rd_ok = ({1'b0, rd_addr} < (IDW + 1)'(ENTRIES));
	assign wr_ok = ({1'b0, wr_addr} < (IDW + 1)'(ENTRIES));

	// Read port
	assign rd_data = rd_ok ? entry_q[rd_addr] : '0;

	// Write port, table cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ENTRIES; k++) begin
				entry_q[k] <= '0;
			end
		end else if (wr_ok) begin
			if (wr.life_we) begin
				entry_q[wr_addr].life <= wr.life;
			end
			if (wr.meta_we) begin
				entry_q[wr_addr].len    <= wr.len;
				entry_q[wr_addr].expiry <= wr.expiry;
			end
			if (wr.pfx_we) begin
				entry_q[wr_addr].hi <= wr.hi;
				entry_q[wr_addr].lo <= wr.lo;
			end
		end
	end

endmodule

// ===== rtl/pct_unit.sv =====
// Shared refresh and compare unit: handles one entry per cycle, result registered.
module pct_unit import pct_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            issue,
	input  logic [ID_W-1:0] issue_id,
	input  pct_entry_t      ent,
	input  logic [63:0]     addr_hi,
	input  logic [63:0]     addr_lo,
	input  logic [31:0]     now,
	output logic [15:0]     life_new,
	output logic            vld_s1,
	output pct_s1_t         ent_s1
);

	// Refresh of the entry being visited, written back by the caller
	assign life_new = refresh_life(ent.life, ent.expiry, now);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	// Payload register toward the match stage
	always_ff @(posedge clk) begin
		if (issue) begin
			ent_s1.id   <= issue_id;
			ent_s1.life <= life_new;
			ent_s1.len  <= ent.len;
			ent_s1.hi   <= ent.hi;
			ent_s1.lo   <= ent.lo;
			ent_s1.diff <= {ent.hi ^ addr_hi, ent.lo ^ addr_lo};
		end
	end

endmodule

// ===== rtl/prefix_context_table.sv =====
// Prefix context table top level: sequencer, best-match tracking and result register.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_ready  | func ctx_id addr_hi addr_lo new_len lifetime
//          |                      | now_minute
//  out     | out_valid/ out_ready | found res_id res_prefix_len res_lifetime
//          |                      | res_prefix_hi res_prefix_lo
//
// Lookup by address visits all ENTRIES entries: the single refresh/compare unit
// visits one entry per cycle, then ST_DRAIN takes the last match and ST_DONE loads
// the result register. Lookup by id visits only the given entry (ST_SCAN, ST_DRAIN,
// ST_DONE), update goes through ST_UPD and ST_DONE, a rejected transaction straight
// to ST_DONE; the next one is taken in ST_IDLE, entered once the result is loaded.
// Reset clears the whole table at once; no clearing pass.
// in_ready is high only while idle; a finished result waits in the output register
// and the next transaction may be accepted meanwhile, stalling only at its end.
module prefix_context_table import pct_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  ctx_id,
	input  logic [63:0] addr_hi,
	input  logic [63:0] addr_lo,
	input  logic [7:0]  new_len,
	input  logic [15:0] lifetime,
	input  logic [31:0] now_minute,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        found,
	output logic [3:0]  res_id,
	output logic [7:0]  res_prefix_len,
	output logic [15:0] res_lifetime,
	output logic [63:0] res_prefix_hi,
	output logic [63:0] res_prefix_lo
);

	localparam int IDW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	pct_state_t state_q, state_d;

	// Latched request
	logic [1:0]  op_q;
	logic [7:0]  id_q;
	logic [63:0] hi_q, lo_q;
	logic [7:0]  plen_q;
	logic [15:0] life_q;
	logic [31:0] now_q;

	logic [IDW-1:0] cnt_q;
	logic [IDW-1:0] scan_idx;
	logic [IDW-1:0] st_addr;
	logic           last_issue;
	logic           in_ok;
	logic           accept;
	logic           out_free;
	logic           load_out;
	logic           issue;

	pct_entry_t rd_data;
	pct_wr_t    wr;
	logic [15:0] life_new;
	logic        vld_s1;
	pct_s1_t     ent_s1;

	// Best match so far
	logic        hit_q;
	logic [7:0]  best_m_q;
	logic [3:0]  best_id_q;
	logic [7:0]  best_len_q;
	logic [15:0] best_life_q;
	logic [63:0] best_hi_q, best_lo_q;

	// Result register
	logic        out_valid_q;
	logic        found_q;
	logic [3:0]  res_id_q;
	logic [7:0]  res_len_q;
	logic [15:0] res_life_q;
	logic [63:0] res_hi_q, res_lo_q;

	// Update datapath
	logic [7:0]       plen_c;
	logic [PFX_W-1:0] given;
	logic [PFX_W-1:0] new_pfx;
	logic             differs;
	logic             upd_ok;

	// Match stage
	logic [7:0] m;
	logic       qual;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign in_ok    = (ctx_id < 8'(ENTRIES));

	assign scan_idx   = (op_q == FUNC_ID) ? id_q[IDW-1:0] : cnt_q;
	assign last_issue = (op_q == FUNC_ID) || (cnt_q == IDW'(ENTRIES - 1));
	assign st_addr    = (state_q == ST_UPD) ? id_q[IDW-1:0] : scan_idx;

	pct_store #(
		.ENTRIES (ENTRIES),
		.IDW     (IDW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (st_addr),
		.rd_data (rd_data),
		.wr_addr (st_addr),
		.wr      (wr)
	);

	pct_unit u_unit (
		.clk      (clk),
		.arst_n   (arst_n),
		.issue    (issue),
		.issue_id (ID_W'(scan_idx)),
		.ent      (rd_data),
		.addr_hi  (hi_q),
		.addr_lo  (lo_q),
		.now      (now_q),
		.life_new (life_new),
		.vld_s1   (vld_s1),
		.ent_s1   (ent_s1)
	);

	// Update values
	assign plen_c  = (plen_q > MAX_LEN) ? MAX_LEN : plen_q;
	assign given   = {hi_q, lo_q};
	assign differs = (given != {rd_data.hi, rd_data.lo});
	assign new_pfx = differs ? (given & len_mask(plen_c)) : given;
	assign upd_ok  = (life_q != 16'd0) && (plen_q != 8'd0);

	// Match qualification
	assign m    = lead_zeros(ent_s1.diff);
	assign qual = (op_q == FUNC_ID) ? (ent_s1.life != 16'd0) :
		((ent_s1.life != 16'd0) && (ent_s1.len <= m) && (m > best_m_q));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (func)
						FUNC_ADDR: state_d = ST_SCAN;
						FUNC_ID:   state_d = in_ok ? ST_SCAN : ST_DONE;
						FUNC_UPD:  state_d = in_ok ? ST_UPD : ST_DONE;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN: begin
				if (last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_DONE;
			ST_UPD:   state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		load_out = 1'b0;
		wr       = '0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SCAN: begin
				issue      = 1'b1;
				wr.life_we = 1'b1;
				wr.life    = life_new;
			end
			ST_UPD: begin
				wr.life_we = 1'b1;
				wr.life    = upd_ok ? life_q : 16'd0;
				wr.meta_we = upd_ok;
				wr.pfx_we  = upd_ok;
				wr.len     = plen_c;
				wr.expiry  = now_q + 32'(life_q);
				wr.hi      = new_pfx[PFX_W-1:64];
				wr.lo      = new_pfx[63:0];
			end
			ST_DONE:  load_out = out_free;
			ST_DRAIN: ;
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			hit_q       <= 1'b0;
			best_m_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q    <= '0;
				hit_q    <= 1'b0;
				best_m_q <= '0;
			end else begin
				if (issue && !last_issue) begin
					cnt_q <= cnt_q + IDW'(1);
				end
				if (vld_s1 && qual) begin
					hit_q    <= 1'b1;
					best_m_q <= m;
				end
				if (state_q == ST_UPD && upd_ok) begin
					hit_q <= 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= func;
			id_q   <= ctx_id;
			hi_q   <= addr_hi;
			lo_q   <= addr_lo;
			plen_q <= new_len;
			life_q <= lifetime;
			now_q  <= now_minute;
		end
	end

	// Best entry payload
	always_ff @(posedge clk) begin
		if (vld_s1 && qual) begin
			best_id_q   <= ent_s1.id;
			best_len_q  <= ent_s1.len;
			best_life_q <= ent_s1.life;
			best_hi_q   <= ent_s1.hi;
			best_lo_q   <= ent_s1.lo;
		end else if (state_q == ST_UPD) begin
			best_id_q   <= id_q[ID_W-1:0];
			best_len_q  <= plen_c;
			best_life_q <= life_q;
			best_hi_q   <= new_pfx[PFX_W-1:64];
			best_lo_q   <= new_pfx[63:0];
		end
	end

	// Result register, fields zero when nothing found
	always_ff @(posedge clk) begin
		if (load_out) begin
			found_q    <= hit_q;
			res_id_q   <= hit_q ? best_id_q : '0;
			res_len_q  <= hit_q ? best_len_q : '0;
			res_life_q <= hit_q ? best_life_q : '0;
			res_hi_q   <= hit_q ? best_hi_q : '0;
			res_lo_q   <= hit_q ? best_lo_q : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign res_id         = res_id_q;
	assign res_prefix_len = res_len_q;
	assign res_lifetime   = res_life_q;
	assign res_prefix_hi  = res_hi_q;
	assign res_prefix_lo  = res_lo_q;

endmodule

// ===== tb/prefix_context_table_test.sv =====
// Self-checking testbench for the prefix context table: queued stimulus, in-order result checks.
module prefix_context_table_test;
	import pct_pkg::*;

	localparam int         N_CTX      = ENTRIES_DEF;
	localparam logic [1:0] FUNC_NONE  = 2'd3;   // unused code, must be a no-op
	localparam int         IDLE_PCT   = 16;
	localparam int         HOLD_LEN   = 300;
	localparam int         STALL_MAX  = 2000;
	localparam int         DRAIN_WAIT = 30;
	localparam int         N_RANDOM   = 500;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  ctx_id;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [7:0]  plen;
		logic [15:0] life;
		logic [31:0] now;
	} ctx_req_t;

	typedef struct packed {
		logic        found;
		logic [3:0]  id;
		logic [7:0]  len;
		logic [15:0] life;
		logic [63:0] hi;
		logic [63:0] lo;
	} ctx_resp_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	logic      in_fire = 1'b0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	ctx_req_t  cur_req = '0;
	ctx_resp_t dut_resp;

	ctx_req_t  req_q[$];
	ctx_resp_t resp_q[$];
	int        n_total;
	int        n_sent = 0;
	int        n_accepted = 0;
	int        n_results = 0;
	int        err_cnt = 0;
	int        hold_cnt = 0;
	bit        hold_done = 1'b0;
	int        stall_cnt = 0;

	// Shadow copy of the context table
	logic [63:0] tbl_hi[N_CTX];
	logic [63:0] tbl_lo[N_CTX];
	logic [7:0]  tbl_len[N_CTX];
	logic [15:0] tbl_life[N_CTX];
	logic [31:0] tbl_exp[N_CTX];

	prefix_context_table u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (cur_req.func),
		.ctx_id         (cur_req.ctx_id),
		.addr_hi        (cur_req.hi),
		.addr_lo        (cur_req.lo),
		.new_len        (cur_req.plen),
		.lifetime       (cur_req.life),
		.now_minute     (cur_req.now),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.found          (dut_resp.found),
		.res_id         (dut_resp.id),
		.res_prefix_len (dut_resp.len),
		.res_lifetime   (dut_resp.life),
		.res_prefix_hi  (dut_resp.hi),
		.res_prefix_lo  (dut_resp.lo)
	);

	always #5 clk = ~clk;

	// Bring an entry's lifetime up to date for minute now
	function automatic void age_entry(int k, logic [31:0] now);
		logic [31:0] rem;
		if (tbl_life[k] == 16'd0) return;
		if (now >= tbl_exp[k]) begin
			tbl_life[k] = 16'd0;
		end else begin
			rem = tbl_exp[k] - now;
			tbl_life[k] = (rem > 32'd65535) ? 16'hFFFF : rem[15:0];
		end
	endfunction

	// Number of leading bits an entry shares with an address
	function automatic int common_prefix(int k, logic [63:0] hi, logic [63:0] lo);
		logic [127:0] d;
		int           n = 0;
		d = {tbl_hi[k], tbl_lo[k]} ^ {hi, lo};
		while (n < 128 && !d[127 - n]) n++;
		return n;
	endfunction

	function automatic ctx_resp_t entry_view(int k);
		ctx_resp_t r;
		r.found = 1'b1;
		r.id    = k[3:0];
		r.len   = tbl_len[k];
		r.life  = tbl_life[k];
		r.hi    = tbl_hi[k];
		r.lo    = tbl_lo[k];
		return r;
	endfunction

	// Apply one request to the shadow table and return the expected response
	function automatic ctx_resp_t ctx_table_step(ctx_req_t q);
		ctx_resp_t    r;
		int           best;
		int           sel;
		int           m;
		int           k;
		logic [7:0]   len;
		logic [127:0] mask;
		r = '0;
		k = q.ctx_id[3:0];
		case (q.func)
			FUNC_ADDR: begin
				best = 0;
				sel  = -1;
				for (int i = 0; i < N_CTX; i++) begin
					age_entry(i, q.now);
					if (tbl_life[i] != 16'd0) begin
						m = common_prefix(i, q.hi, q.lo);
						if (tbl_len[i] <= m && m > best) begin
							best = m;
							sel  = i;
						end
					end
				end
				if (sel >= 0) r = entry_view(sel);
			end
			FUNC_ID: begin
				if (q.ctx_id < N_CTX) begin
					age_entry(k, q.now);
					if (tbl_life[k] != 16'd0) r = entry_view(k);
				end
			end
			FUNC_UPD: begin
				if (q.ctx_id < N_CTX) begin
					if (q.life == 16'd0 || q.plen == 8'd0) begin
						tbl_life[k] = 16'd0;
					end else begin
						len = (q.plen > MAX_LEN) ? MAX_LEN : q.plen;
						tbl_life[k] = q.life;
						tbl_len[k]  = len;
						// an identical prefix is kept as stored, unmasked
						if ({tbl_hi[k], tbl_lo[k]} != {q.hi, q.lo}) begin
							mask = {128{1'b1}} << (8'd128 - len);
							{tbl_hi[k], tbl_lo[k]} = {q.hi, q.lo} & mask;
						end
						tbl_exp[k] = q.now + {16'd0, q.life};
						r = entry_view(k);
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
		err_cnt++;
	endtask

	task automatic add_req(logic [1:0] func, logic [7:0] id, logic [127:0] pfx,
		logic [7:0] plen, logic [15:0] life, logic [31:0] now);
		ctx_req_t q;
		q.func   = func;
		q.ctx_id = id;
		{q.hi, q.lo} = pfx;
		q.plen   = plen;
		q.life   = life;
		q.now    = now;
		req_q.push_back(q);
	endtask

	// Sender: new transaction at the falling edge once the previous one is taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (req_q.size() != 0 &&
				((n_sent >= 200 && n_sent < 320) || $urandom_range(99) >= IDLE_PCT)) begin
				cur_req  <= req_q.pop_front();
				in_valid <= 1'b1;
				n_sent++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, one long hold-off, one stretch always ready
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cnt != 0) begin
				hold_cnt  <= hold_cnt - 1;
				out_ready <= 1'b0;
			end else if (n_results == 40 && !hold_done) begin
				hold_cnt  <= HOLD_LEN;
				hold_done <= 1'b1;
				out_ready <= 1'b0;
			end else if (n_results >= 250 && n_results < 380) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin
		ctx_resp_t want;
		if (arst_n) begin
			in_fire <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				resp_q.push_back(ctx_table_step(cur_req));
				n_accepted++;
			end
			if (out_valid && out_ready) begin
				n_results++;
				if (resp_q.size() == 0) begin
					report_mismatch("result with nothing pending", 64'(dut_resp.found),
						64'd0);
				end else begin
					want = resp_q.pop_front();
					if (dut_resp.found !== want.found)
						report_mismatch("found", 64'(dut_resp.found), 64'(want.found));
					if (dut_resp.id !== want.id)
						report_mismatch("res_id", 64'(dut_resp.id), 64'(want.id));
					if (dut_resp.len !== want.len)
						report_mismatch("res_prefix_len", 64'(dut_resp.len), 64'(want.len));
					if (dut_resp.life !== want.life)
						report_mismatch("res_lifetime", 64'(dut_resp.life), 64'(want.life));
					if (dut_resp.hi !== want.hi)
						report_mismatch("res_prefix_hi", dut_resp.hi, want.hi);
					if (dut_resp.lo !== want.lo)
						report_mismatch("res_prefix_lo", dut_resp.lo, want.lo);
				end
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cnt <= 0;
			end else if (stall_cnt >= STALL_MAX) begin
				$display("timeout: no transaction for %0d cycles", STALL_MAX);
				$display("prefix_context_table_test: FAIL");
				$finish;
			end else begin
				stall_cnt <= stall_cnt + 1;
			end
		end
	end

	initial begin
		logic [127:0] base[4];
		logic [127:0] ones;
		logic [127:0] pfx;
		logic [31:0]  now_t;
		logic [1:0]   func;
		logic [7:0]   id;
		logic [7:0]   plen;
		logic [15:0]  life;
		int           pick;
		int           b;

		for (int k = 0; k < N_CTX; k++) begin
			tbl_hi[k]   = '0;
			tbl_lo[k]   = '0;
			tbl_len[k]  = '0;
			tbl_life[k] = '0;
			tbl_exp[k]  = '0;
		end
		ones = {128{1'b1}};

		// Directed: empty table, clamping, range checks, equal prefix, removal
		add_req(FUNC_ADDR, 8'd0,   ones, 8'd0,   16'd0,     32'd0);
		add_req(FUNC_ID,   8'd0,   '0,   8'd0,   16'd0,     32'd0);
		add_req(FUNC_UPD,  8'd0,   ones, 8'd255, 16'hFFFF,  32'd0);
		add_req(FUNC_UPD,  8'd15,  ones, 8'd1,   16'd1,     32'd0);
		add_req(FUNC_UPD,  8'd16,  ones, 8'd64,  16'd10,    32'd0);
		add_req(FUNC_UPD,  8'd255, ones, 8'd64,  16'd10,    32'd0);
		add_req(FUNC_ID,   8'd255, ones, 8'd64,  16'd10,    32'd0);
		add_req(FUNC_NONE, 8'd255, ones, 8'd255, 16'hFFFF,  32'd0);
		add_req(FUNC_ADDR, 8'd0,   ones, 8'd0,   16'd0,     32'd0);
		add_req(FUNC_ADDR, 8'd0,   {1'b1, 127'd0}, 8'd0, 16'd0, 32'd0);
		add_req(FUNC_ADDR, 8'd0,   '0,   8'd0,   16'd0,     32'd0);
		// same prefix, shorter length: stored prefix stays all ones
		add_req(FUNC_UPD,  8'd0,   ones, 8'd8,   16'd100,   32'd0);
		add_req(FUNC_ID,   8'd0,   '0,   8'd0,   16'd0,     32'd0);
		// entry expiring exactly at its expiry minute
		add_req(FUNC_ID,   8'd15,  '0,   8'd0,   16'd0,     32'd1);
		add_req(FUNC_UPD,  8'd1,   {64'h0123456789ABCDEF, 64'hFEDCBA9876543210},
			8'd65, 16'd50, 32'd1);
		add_req(FUNC_UPD,  8'd1,   ones, 8'd0,   16'd50,    32'd2);
		add_req(FUNC_ID,   8'd1,   '0,   8'd0,   16'd0,     32'd2);
		add_req(FUNC_UPD,  8'd0,   ones, 8'd8,   16'd0,     32'd2);
		add_req(FUNC_ID,   8'd0,   '0,   8'd0,   16'd0,     32'd2);
		// expiry wrapping past the top of the minute counter
		add_req(FUNC_UPD,  8'd2,   ones, 8'd128, 16'h0100,  32'hFFFF_FFF0);
		add_req(FUNC_ID,   8'd2,   '0,   8'd0,   16'd0,     32'hFFFF_FFF0);
		// clock stepping back: remaining time saturates
		add_req(FUNC_UPD,  8'd3,   {64'hFFFF_0000_0000_0000, 64'd0}, 8'd16, 16'hFFFF,
			32'd100000);
		add_req(FUNC_ID,   8'd3,   '0,   8'd0,   16'd0,     32'd0);
		add_req(FUNC_ADDR, 8'd0,   {64'hFFFF_1234_0000_0000, 64'd5}, 8'd0, 16'd0, 32'd1);

		// Random: requests built around a few shared prefixes so lookups hit
		for (int i = 0; i < 4; i++) base[i] = {$urandom, $urandom, $urandom, $urandom};
		now_t = $urandom_range(1000);
		for (int i = 0; i < N_RANDOM; i++) begin
			pick = $urandom_range(99);
			if (pick < 2)       now_t = now_t + $urandom_range(70000);
			else if (pick == 2) now_t = now_t - $urandom_range(70000);
			else if (pick == 3) now_t = 32'hFFFF_FFFF - $urandom_range(300);
			else if (pick == 4) now_t = $urandom;
			else                now_t = now_t + $urandom_range(3);

			pfx = base[$urandom_range(3)];
			pick = $urandom_range(9);
			if (pick == 0) begin
				pfx = {$urandom, $urandom, $urandom, $urandom};
			end else if (pick < 4) begin
				b = $urandom_range(127);
				pfx[b] = ~pfx[b];
			end else if (pick < 7) begin
				pfx = pfx ^ ({$urandom, $urandom, $urandom, $urandom} >> $urandom_range(128));
			end

			pick = $urandom_range(99);
			if (pick < 38)      func = FUNC_ADDR;
			else if (pick < 58) func = FUNC_ID;
			else if (pick < 95) func = FUNC_UPD;
			else                func = FUNC_NONE;

			id = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));

			pick = $urandom_range(9);
			if (pick == 0)      plen = 8'($urandom_range(255));
			else if (pick == 1) plen = 8'd0;
			else if (pick == 2) plen = MAX_LEN;
			else                plen = 8'($urandom_range(1, 128));

			pick = $urandom_range(9);
			if (pick == 0)      life = 16'd0;
			else if (pick == 1) life = 16'($urandom_range(65535));
			else if (pick == 2) life = 16'hFFFF;
			else                life = 16'($urandom_range(1, 300));

			add_req(func, id, pfx, plen, life, now_t);
		end
		n_total = req_q.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait until everything has been taken and answered, then let the block settle
		while (n_accepted < n_total || resp_q.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (err_cnt == 0 && resp_q.size() == 0) begin
			$display("prefix_context_table_test: PASS");
		end else begin
			$display("prefix_context_table_test: FAIL");
		end
		$finish;
	end

endmodule
